// ===== hw/rtl/sstf_pkg.sv =====
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared constants and types for the shortest-seek-time-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int unsigned MaxRequests = 8;
  localparam int unsigned CylBits     = 10;
  localparam int unsigned IdxBits     = $clog2(MaxRequests);
  localparam int unsigned CntBits     = $clog2(MaxRequests + 1);
  localparam int unsigned TotalBits   = 13;
  localparam int unsigned InDataBits  = 16;
  localparam int unsigned OutDataBits = 40;
  localparam int unsigned OutUsedBits = CylBits + IdxBits + CylBits + TotalBits;

  localparam logic [CntBits-1:0] MaxCount = CntBits'(MaxRequests);

  typedef enum logic [2:0] {
    StLoad = 3'b001,
    StScan = 3'b010,
    StEmit = 3'b100
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // store the accepted request
    logic start;  // begin service from the start cylinder
    logic step;   // examine one stored entry
    logic emit;   // commit the best entry into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // entry under examination is the last stored one
    logic out_free;   // output register can take a result this cycle
    logic final_hit;  // the pending result is the last of the batch
  } status_t;

endpackage

// ===== hw/rtl/sstf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sstf_ctrl
// Sequencer: loads a batch, then alternates entry scans and result commits.
// ----------------------------------------------------------------------------
module sstf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  sstf_pkg::status_t status_i,
  output sstf_pkg::cmd_t    cmd_o
);

  sstf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sstf_pkg::StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sstf_pkg::StLoad: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.start = 1'b1;
            state_d     = sstf_pkg::StScan;
          end
        end
      end
      sstf_pkg::StScan: begin
        cmd_o.step = 1'b1;
        if (status_i.scan_last) begin
          state_d = sstf_pkg::StEmit;
        end
      end
      sstf_pkg::StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.final_hit ? sstf_pkg::StLoad : sstf_pkg::StScan;
        end
      end
      default: begin
        state_d = sstf_pkg::StLoad;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sstf_datapath.sv =====
// ----------------------------------------------------------------------------
// sstf_datapath
// Request store, served flags, nearest-entry scan and the output register.
// ----------------------------------------------------------------------------
module sstf_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [sstf_pkg::CylBits-1:0]       cfg_data_i,
  input  logic [sstf_pkg::CylBits-1:0]       in_cyl_i,
  input  sstf_pkg::cmd_t                     cmd_i,
  output sstf_pkg::status_t                  status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sstf_pkg::OutDataBits-1:0]   out_data_o,
  output logic                               out_user_o,
  output logic                               out_last_o
);

  logic [sstf_pkg::CylBits-1:0]   store_q [sstf_pkg::MaxRequests];
  logic [sstf_pkg::MaxRequests-1:0] flags_q;
  logic [sstf_pkg::CntBits-1:0]   count_q, served_q;
  logic                           ovf_q;
  logic [sstf_pkg::CylBits-1:0]   start_q, head_q;
  logic [sstf_pkg::TotalBits-1:0] total_q;
  logic [sstf_pkg::IdxBits-1:0]   scan_idx_q, best_idx_q;
  logic [sstf_pkg::CylBits-1:0]   best_dist_q, best_cyl_q;
  logic                           found_q;
  logic                           out_valid_q;
  logic [sstf_pkg::OutUsedBits-1:0] out_data_q;
  logic                           out_user_q, out_last_q;

  logic [sstf_pkg::CylBits-1:0]   scan_cyl, scan_dist;
  logic                           take;
  logic [sstf_pkg::TotalBits-1:0] total_next;
  logic                           final_hit;

  assign scan_cyl   = store_q[scan_idx_q];
  assign scan_dist  = (scan_cyl > head_q) ? (scan_cyl - head_q) : (head_q - scan_cyl);
  // strict compare keeps the earliest-loaded entry on a tie
  assign take       = !flags_q[scan_idx_q] && (!found_q || (scan_dist < best_dist_q));
  assign total_next = total_q + sstf_pkg::TotalBits'(best_dist_q);
  assign final_hit  = ((served_q + 1'b1) == count_q);

  assign status_o.scan_last = ({1'b0, scan_idx_q} == (count_q - 1'b1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.final_hit = final_hit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < sstf_pkg::MaxCount)) begin
      store_q[count_q[sstf_pkg::IdxBits-1:0]] <= in_cyl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_valid_i) begin
      start_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      count_q     <= '0;
      served_q    <= '0;
      ovf_q       <= 1'b0;
      head_q      <= '0;
      total_q     <= '0;
      scan_idx_q  <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!cmd_i.emit && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        if (count_q < sstf_pkg::MaxCount) begin
          count_q <= count_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.start) begin
        head_q     <= start_q;
        served_q   <= '0;
        scan_idx_q <= '0;
        found_q    <= 1'b0;
      end
      if (cmd_i.step) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        head_q      <= best_cyl_q;
        scan_idx_q  <= '0;
        found_q     <= 1'b0;
        if (final_hit) begin
          flags_q  <= '0;
          count_q  <= '0;
          served_q <= '0;
          ovf_q    <= 1'b0;
          total_q  <= '0;
        end else begin
          flags_q[best_idx_q] <= 1'b1;
          served_q            <= served_q + 1'b1;
          total_q             <= total_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && take) begin
      best_idx_q  <= scan_idx_q;
      best_dist_q <= scan_dist;
      best_cyl_q  <= scan_cyl;
    end
    if (cmd_i.emit) begin
      out_data_q <= {total_next, best_dist_q, best_idx_q, best_cyl_q};
      out_user_q <= ovf_q;
      out_last_q <= final_hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = sstf_pkg::OutDataBits'(out_data_q);
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sstf_pkg::MaxCount)
    else $error("request count beyond store depth");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (count_q != '0) && found_q)
    else $error("result committed without a candidate");

  a_emit_unserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !flags_q[best_idx_q])
    else $error("served entry picked again");

  a_batch_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && final_hit |=> (count_q == '0) && (flags_q == '0) && !ovf_q)
    else $error("batch state not cleared after last result");

endmodule

// ===== hw/rtl/sstf_seek_scheduler.sv =====
// ----------------------------------------------------------------------------
// sstf_seek_scheduler
// Shortest-seek-time-first scheduler for a batch of up to eight cylinders.
// ----------------------------------------------------------------------------
// Requests load one per cycle while the sequencer is in its load state; the
// transfer with tlast starts service from the configured start cylinder, and
// requests past the eighth are dropped and flagged in tuser. Each result takes
// a nearest-entry scan over every stored request, a single entry at a time,
// then a commit into the output register, which waits while that register is
// still full and not being taken. The output register lets the next batch
// start loading while the last result of the previous one waits to be taken.
module sstf_seek_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: start_cylinder
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [9:0] cylinder
  input  logic        s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [9:0] served_cylinder, [12:10] served_index, [22:13] seek_distance,
  // [35:23] total_moves
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // dropped
  output logic        m_axis_tlast_o    // final_res
);

  sstf_pkg::cmd_t    cmd;
  sstf_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  sstf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sstf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_cyl_i    (s_axis_tdata_i[sstf_pkg::CylBits-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shortest-seek-time-first seek scheduler.
// ----------------------------------------------------------------------------
// Batches of cylinder requests go in on the slave stream. Each accepted transfer
// runs through a local scheduling model that builds the expected service order.
// Every result on the master stream is checked field by field against the
// oldest entry of that order. A short table of hand-picked requests comes
// first: extremes, ties, duplicates and an overfull store. After it come random
// batches in four phases: no stalls, sender idling, receiver stalling and both,
// with the start cylinder rewritten before each phase while the scheduler is idle.
module tb_top;

  localparam int DrainCycles   = 80;
  localparam int WatchdogLimit = 3000;
  localparam int PhaseItems    = 48;

  typedef struct packed {
    logic [sstf_pkg::CylBits-1:0]   cyl;
    logic [sstf_pkg::IdxBits-1:0]   idx;
    logic [sstf_pkg::CylBits-1:0]   seek;
    logic [sstf_pkg::TotalBits-1:0] total;
    logic                           dropped;
    logic                           last_flag;
  } result_t;

  typedef struct packed {
    logic [sstf_pkg::CylBits-1:0] cyl;
    logic                         last;
    logic                         typed;  // want holds a hand-written single result
    result_t                      want;
  } stim_row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [sstf_pkg::CylBits-1:0]     cfg_data_i;
  logic                             s_axis_tvalid_i;
  logic                             s_axis_tready_o;
  logic [sstf_pkg::InDataBits-1:0]  s_axis_tdata_i;
  logic                             s_axis_tlast_i;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i;
  logic [sstf_pkg::OutDataBits-1:0] m_axis_tdata_o;
  logic                             m_axis_tuser_o;
  logic                             m_axis_tlast_o;

  sstf_seek_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // scheduling model state
  logic [sstf_pkg::CylBits-1:0] start_cyl;
  logic [sstf_pkg::CylBits-1:0] batch_cyl [sstf_pkg::MaxRequests];
  int unsigned                  batch_len;
  bit                           batch_overflow;
  result_t                      service_order [$];
  result_t                      expected_results [$];

  int sender_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int results_seen;
  int quiet_cycles;

  result_t got_result;
  result_t want_result;

  stim_row_t directed_rows [18] = '{
    '{10'd1023, 1'b1, 1'b1, '{10'd1023, 3'd0, 10'd1023, 13'd1023, 1'b0, 1'b1}},
    '{10'd0,    1'b1, 1'b1, '{10'd0,    3'd0, 10'd0,    13'd0,    1'b0, 1'b1}},
    // a duplicate cylinder is served in arrival order
    '{10'd20,   1'b0, 1'b0, '0},
    '{10'd30,   1'b0, 1'b0, '0},
    '{10'd10,   1'b0, 1'b0, '0},
    '{10'd20,   1'b1, 1'b0, '0},
    '{10'd7,    1'b0, 1'b0, '0},
    '{10'd7,    1'b1, 1'b0, '0},
    // ten requests into eight entries, the tlast transfer itself is dropped
    '{10'd1023, 1'b0, 1'b0, '0},
    '{10'd0,    1'b0, 1'b0, '0},
    '{10'd512,  1'b0, 1'b0, '0},
    '{10'd511,  1'b0, 1'b0, '0},
    '{10'd341,  1'b0, 1'b0, '0},
    '{10'd682,  1'b0, 1'b0, '0},
    '{10'd1,    1'b0, 1'b0, '0},
    '{10'd1022, 1'b0, 1'b0, '0},
    '{10'd300,  1'b0, 1'b0, '0},
    '{10'd700,  1'b1, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic plan_service(input logic [sstf_pkg::CylBits-1:0] cyl, input bit last);
    bit                           served [sstf_pkg::MaxRequests];
    logic [sstf_pkg::CylBits-1:0] head;
    int unsigned                  run_total;
    int unsigned                  d;
    int unsigned                  best_d;
    int                           best;
    result_t                      r;
    if (batch_len < sstf_pkg::MaxRequests) begin
      batch_cyl[batch_len] = cyl;
      batch_len++;
    end else begin
      batch_overflow = 1'b1;
    end
    if (!last) return;
    head      = start_cyl;
    run_total = 0;
    foreach (served[i]) served[i] = 1'b0;
    for (int k = 0; k < int'(batch_len); k++) begin
      best   = -1;
      best_d = 0;
      for (int i = 0; i < int'(batch_len); i++) begin
        if (!served[i]) begin
          d = (batch_cyl[i] > head) ? batch_cyl[i] - head : head - batch_cyl[i];
          // strict compare keeps the earliest request on a tie
          if (best < 0 || d < best_d) begin
            best   = i;
            best_d = d;
          end
        end
      end
      served[best] = 1'b1;
      run_total   += best_d;
      head         = batch_cyl[best];
      r.cyl        = batch_cyl[best];
      r.idx        = sstf_pkg::IdxBits'(best);
      r.seek       = sstf_pkg::CylBits'(best_d);
      r.total      = sstf_pkg::TotalBits'(run_total);
      r.dropped    = batch_overflow;
      r.last_flag  = (k == int'(batch_len) - 1);
      service_order.push_back(r);
    end
    batch_len      = 0;
    batch_overflow = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on result %0d: %s got %0d, expected %0d",
             $time, results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.cyl != want.cyl) report_mismatch("served_cylinder", got.cyl, want.cyl);
    if (got.idx != want.idx) report_mismatch("served_index", got.idx, want.idx);
    if (got.seek != want.seek) report_mismatch("seek_distance", got.seek, want.seek);
    if (got.total != want.total) report_mismatch("total_moves", got.total, want.total);
    if (got.dropped != want.dropped) report_mismatch("dropped", got.dropped, want.dropped);
    if (got.last_flag != want.last_flag)
      report_mismatch("final_res", got.last_flag, want.last_flag);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_result.cyl       = m_axis_tdata_o[9:0];
      got_result.idx       = m_axis_tdata_o[12:10];
      got_result.seek      = m_axis_tdata_o[22:13];
      got_result.total     = m_axis_tdata_o[35:23];
      got_result.dropped   = m_axis_tuser_o;
      got_result.last_flag = m_axis_tlast_o;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, cylinder", got_result.cyl, -1);
      end else begin
        want_result = expected_results.pop_front();
        check_result(got_result, want_result);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, WatchdogLimit);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic [sstf_pkg::CylBits-1:0] cyl, input bit last,
                              input bit typed, input result_t want);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= sstf_pkg::InDataBits'(cyl);
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    plan_service(cyl, last);
    if (typed) begin
      expected_results.push_back(want);
    end else begin
      foreach (service_order[i]) expected_results.push_back(service_order[i]);
    end
    service_order.delete();
  endtask

  // drop tvalid, then wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_start_cylinder(input logic [sstf_pkg::CylBits-1:0] value);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    start_cyl = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [sstf_pkg::CylBits-1:0] pick_cylinder(input bit near_head);
    int v;
    if (near_head) begin
      // cluster around the start cylinder to force ties on both sides
      v = int'(start_cyl) + int'($urandom_range(0, 16)) - 8;
    end else begin
      case ($urandom_range(0, 9))
        0:       v = 0;
        1:       v = 1023;
        default: v = int'($urandom_range(0, 1023));
      endcase
    end
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return sstf_pkg::CylBits'(v);
  endfunction

  initial begin
    int      batch_size;
    int      phase_items;
    bit      near_head;
    result_t no_want;
    int      idle_modes [4][2];
    logic [sstf_pkg::CylBits-1:0] phase_start [4];

    idle_modes      = '{'{0, 0}, '{54, 0}, '{0, 54}, '{29, 29}};
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    mismatches      = 0;
    results_seen    = 0;
    quiet_cycles    = 0;
    start_cyl       = '0;
    batch_len       = 0;
    batch_overflow  = 1'b0;
    no_want         = '0;
    phase_start[0]  = 10'd1023;
    phase_start[1]  = 10'd0;
    phase_start[2]  = sstf_pkg::CylBits'($urandom_range(1, 1022));
    phase_start[3]  = sstf_pkg::CylBits'($urandom_range(1, 1022));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // start cylinder still at its reset value here
    foreach (directed_rows[i])
      send_request(directed_rows[i].cyl, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      write_start_cylinder(phase_start[ph]);
      sender_idle_pct = idle_modes[ph][0];
      recv_stall_pct  = idle_modes[ph][1];
      phase_items     = 0;
      while (phase_items < PhaseItems) begin
        batch_size = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 11))
                                                 : int'($urandom_range(1, 8));
        near_head  = ($urandom_range(0, 2) == 0);
        for (int j = 0; j < batch_size; j++)
          send_request(pick_cylinder(near_head), j == batch_size - 1, 1'b0, no_want);
        phase_items += batch_size;
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sstf_pkg.sv
hw/rtl/sstf_ctrl.sv
hw/rtl/sstf_datapath.sv
hw/rtl/sstf_seek_scheduler.sv
tb/tb_top.sv
